// ===== hdl/p1305_pkg.sv =====
// shared types, constants and a helper function for the poly1305 mac
`default_nettype none
package p1305_pkg;

  localparam int LIMBS  = 5;
  localparam int LIMB_W = 26;
  localparam int H_W    = 27;   // accumulator limb plus message limb
  localparam int W_W    = 29;   // r limb times five
  localparam int P_W    = 56;   // one partial product
  localparam int D_W    = 59;   // sum of five partial products plus carries
  localparam int CY_W   = D_W - LIMB_W;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [63:0] CLAMP_LO = 64'h0ffffffc0fffffff;
  localparam logic [63:0] CLAMP_HI = 64'h0ffffffc0ffffffc;

  // register indexes, byte address is 8 times the index
  localparam logic [1:0] REG_R_LOW  = 2'd0;
  localparam logic [1:0] REG_R_HIGH = 2'd1;
  localparam logic [1:0] REG_S_LOW  = 2'd2;
  localparam logic [1:0] REG_S_HIGH = 2'd3;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [H_W-1:0]    hlimb_t;
  typedef logic [W_W-1:0]    wlimb_t;
  typedef logic [P_W-1:0]    prod_t;
  typedef logic [D_W-1:0]    dlimb_t;

  typedef struct packed {
    logic [63:0] msg_low;
    logic [63:0] msg_high;
    logic [4:0]  byte_count;
    logic        last;
  } msg_t;

  typedef struct packed {
    logic [63:0] tag_low;
    logic [63:0] tag_high;
  } tag_t;

  typedef struct packed {
    logic [127:0] r;
    logic [127:0] s;
  } key_t;

  // pad a block: full block gets bit 128, partial block a 0x01 byte after its data
  function automatic logic [129:0] pad_block(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [4:0] n);
    logic [5:0]   sh;
    logic [63:0]  bit_m;
    logic [63:0]  keep;
    logic [129:0] v;
    sh    = {n[2:0], 3'b000};
    bit_m = 64'd1 << sh;
    keep  = bit_m - 64'd1;
    if (n[4]) begin
      v = {2'b01, hi, lo};
    end else if (n[3]) begin
      v = {2'b00, (hi & keep) | bit_m, lo};
    end else begin
      v = {66'd0, (lo & keep) | bit_m};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/p1305_regs.sv =====
// apb key registers for the poly1305 mac
`default_nettype none
module p1305_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [p1305_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [p1305_pkg::DATA_W-1:0]    pwdata,
  output logic      [p1305_pkg::DATA_W-1:0]    prdata,
  output logic                                 pready,
  output p1305_pkg::key_t                      key
);
  import p1305_pkg::*;

  logic [63:0] r_low;
  logic [63:0] r_high;
  logic [63:0] s_low;
  logic [63:0] s_high;
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[4:3];
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_low  <= '0;
      r_high <= '0;
      s_low  <= '0;
      s_high <= '0;
    end else if (wr) begin
      case (idx)
        REG_R_LOW:  r_low  <= pwdata;
        REG_R_HIGH: r_high <= pwdata;
        REG_S_LOW:  s_low  <= pwdata;
        REG_S_HIGH: s_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_R_LOW:  prdata = r_low;
      REG_R_HIGH: prdata = r_high;
      REG_S_LOW:  prdata = s_low;
      REG_S_HIGH: prdata = s_high;
      default:    prdata = '0;
    endcase
  end

  // r in the upper half of the key, s in the lower
  assign key = {r_high, r_low, s_high, s_low};

endmodule
`default_nettype wire

// ===== hdl/p1305_mul_row.sv =====
// row of five limb multipliers with registered products
`default_nettype none
module p1305_mul_row (
  input  wire logic                                    clk,
  input  wire logic [p1305_pkg::LIMBS-1:0][p1305_pkg::H_W-1:0] h,
  input  wire logic [p1305_pkg::LIMBS-1:0][p1305_pkg::W_W-1:0] w,
  output logic      [p1305_pkg::LIMBS-1:0][p1305_pkg::P_W-1:0] prod
);
  import p1305_pkg::*;

  always_ff @(posedge clk) begin
    for (int j = 0; j < LIMBS; j++) begin
      prod[j] <= P_W'(h[j]) * P_W'(w[j]);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/p1305_core.sv =====
// poly1305 sequencer: row multiply, carry folding and tag finish
`default_nettype none
module p1305_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire p1305_pkg::key_t key,
  input  wire p1305_pkg::msg_t msg,
  input  wire logic            msg_valid,
  output logic                 msg_ready,
  output p1305_pkg::tag_t      tag,
  output logic                 tag_valid,
  input  wire logic            tag_ready
);
  import p1305_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_CARRY = 3'd2;
  localparam logic [2:0] ST_FIN1  = 3'd3;
  localparam logic [2:0] ST_FIN2  = 3'd4;

  logic [2:0]   state;
  logic [2:0]   cnt;
  logic [1:0]   pass;
  logic         last_q;
  logic [127:0] fin;

  logic [LIMBS-1:0][LIMB_W-1:0] acc;
  logic [LIMBS-1:0][H_W-1:0]    h;
  logic [LIMBS-1:0][W_W-1:0]    w;
  logic [LIMBS-1:0][D_W-1:0]    d;
  logic [LIMBS-1:0][P_W-1:0]    prod;

  logic [LIMBS-1:0][LIMB_W-1:0] r_l;
  logic [LIMBS-1:0][W_W-1:0]    s5;
  logic [LIMBS-1:0][H_W-1:0]    h_load;
  logic [LIMBS-1:0][W_W-1:0]    w_row0;
  logic [LIMBS-1:0][D_W-1:0]    rot_next;
  logic [129:0] r_flat;
  logic [129:0] m_flat;
  logic [129:0] acc_flat;
  logic [130:0] acc_p5;
  logic [127:0] tag_sum;
  logic [D_W-1:0] sum_row;
  logic [W_W-1:0] r_next;
  logic [CY_W-1:0] carry;
  logic [D_W-1:0]  add_v;
  logic accept;
  logic tag_load;

  assign msg_ready = (state == ST_IDLE);
  assign accept    = msg_valid & msg_ready;
  assign tag_load  = (state == ST_FIN2) && (!tag_valid || tag_ready);

  // clamped r split into limbs, and the times-five limbs for wrapped terms
  assign r_flat = {2'b00, key.r[127:64] & CLAMP_HI, key.r[63:0] & CLAMP_LO};
  assign m_flat = pad_block(msg.msg_low, msg.msg_high, msg.byte_count);
  assign acc_flat = acc;

  always_comb begin
    for (int i = 0; i < LIMBS; i++) begin
      r_l[i]    = r_flat[LIMB_W*i +: LIMB_W];
      s5[i]     = {3'b000, r_l[i]} + {1'b0, r_l[i], 2'b00};
      h_load[i] = {1'b0, acc[i]} + {1'b0, m_flat[LIMB_W*i +: LIMB_W]};
    end
  end

  // row k uses r[k-j] for j <= k and 5*r[k+5-j] past the wrap
  assign w_row0 = {s5[1], s5[2], s5[3], s5[4], W_W'(r_l[0])};

  always_comb begin
    case (cnt)
      3'd0:    r_next = W_W'(r_l[1]);
      3'd1:    r_next = W_W'(r_l[2]);
      3'd2:    r_next = W_W'(r_l[3]);
      3'd3:    r_next = W_W'(r_l[4]);
      default: r_next = W_W'(r_l[0]);
    endcase
  end

  assign sum_row = D_W'(prod[0]) + D_W'(prod[1]) + D_W'(prod[2])
                 + D_W'(prod[3]) + D_W'(prod[4]);

  // one carry step on the limb at the bottom, then the limbs rotate down
  assign carry = d[0][D_W-1:LIMB_W];
  assign add_v = (cnt == 3'd4) ? D_W'({carry, 2'b00}) + D_W'(carry) : D_W'(carry);

  always_comb begin
    rot_next[0] = d[1] + add_v;
    rot_next[1] = d[2];
    rot_next[2] = d[3];
    rot_next[3] = d[4];
    rot_next[4] = D_W'(d[0][LIMB_W-1:0]);
  end

  assign acc_p5  = {1'b0, acc_flat} + 131'd5;
  assign tag_sum = fin + key.s;

  p1305_mul_row u_mul_row (
    .clk  (clk),
    .h    (h),
    .w    (w),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pass      <= '0;
      tag_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (tag_valid && tag_ready && !tag_load) begin
        tag_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (msg.byte_count != 5'd0) begin
              state <= ST_MUL;
            end else if (msg.last) begin
              state <= ST_FIN1;
            end
          end
        end
        ST_MUL: begin
          if (cnt == 3'd5) begin
            state <= ST_CARRY;
            cnt   <= '0;
            pass  <= '0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_CARRY: begin
          if (cnt == 3'd4) begin
            cnt <= '0;
            if (pass == 2'd2) begin
              for (int i = 0; i < LIMBS; i++) begin
                acc[i] <= rot_next[i][LIMB_W-1:0];
              end
              state <= last_q ? ST_FIN1 : ST_IDLE;
            end else begin
              pass <= pass + 2'd1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_FIN1: begin
          state <= ST_FIN2;
        end
        ST_FIN2: begin
          if (tag_load) begin
            tag_valid <= 1'b1;
            acc       <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          last_q <= msg.last;
          h      <= h_load;
          w      <= w_row0;
        end
      end
      ST_MUL: begin
        if (cnt != 3'd0) begin
          d <= {sum_row, d[4:1]};
        end
        if (cnt < 3'd4) begin
          w <= {w[3:0], r_next};
        end
      end
      ST_CARRY: begin
        d <= rot_next;
      end
      ST_FIN1: begin
        // h + 5 reaching 2^130 means h >= p, and h - p is its low bits
        fin <= acc_p5[130] ? acc_p5[127:0] : acc_flat[127:0];
      end
      ST_FIN2: begin
        if (tag_load) begin
          tag.tag_low  <= tag_sum[63:0];
          tag.tag_high <= tag_sum[127:64];
        end
      end
      default: ;
    endcase
  end

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= 3'd5))
    else $error("multiply row count out of range");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    tag_load |=> (acc == '0))
    else $error("accumulator not cleared after tag");

  a_tag_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN2 && tag_valid && !tag_ready) |=> (state == ST_FIN2))
    else $error("tag overwritten while waiting");

  a_empty_block: assert property (@(posedge clk) disable iff (rst)
    (accept && msg.byte_count == 5'd0 && !msg.last) |=> (state == ST_IDLE))
    else $error("empty block started work");

  a_carry_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CARRY) |-> (pass <= 2'd2 && cnt <= 3'd4))
    else $error("carry sequencer out of range");

endmodule
`default_nettype wire

// ===== hdl/poly1305_mac_radix26_top.sv =====
// poly1305 mac top: apb key registers and the shared-multiplier core
// a block with data passes the five-multiplier row (one limb row a cycle) and then
// 15 single carry steps before the next block can be taken
// a last block then goes through the finish states FIN1 and FIN2, and an empty last
// block goes straight to FIN1; the tag register frees the input side
// synchronous reset clears keys, accumulator and control; no clearing pass
`default_nettype none
module poly1305_mac_radix26_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [p1305_pkg::ADDR_W-1:0] paddr,
  input  wire logic [p1305_pkg::DATA_W-1:0] pwdata,
  output logic      [p1305_pkg::DATA_W-1:0] prdata,
  output logic                              pready,
  input  wire p1305_pkg::msg_t              msg,
  input  wire logic                         msg_valid,
  output logic                              msg_ready,
  output p1305_pkg::tag_t                   tag,
  output logic                              tag_valid,
  input  wire logic                         tag_ready
);
  import p1305_pkg::*;

  key_t key;

  p1305_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  p1305_core u_core (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .msg       (msg),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .tag       (tag),
    .tag_valid (tag_valid),
    .tag_ready (tag_ready)
  );

endmodule
`default_nettype wire
